@@ hw/rtl/slabnt_pkg.sv @@
package slabnt_pkg;

	// Parameter defaults
	localparam int FRAC_BITS_DEF      = 16;
	localparam int COUNT_WIDTH_DEF    = 32;
	localparam int LOG_ITERATIONS_DEF = 16;

	// Fixed field widths
	localparam int DRAW_W    = 16;
	localparam int POS_W     = 24;
	localparam int THR_W     = 17;
	localparam int DIR_W     = 18;
	localparam int MAG_W     = 17;
	localparam int OUT_CNT_W = 32;
	localparam int Y_W       = 64;
	localparam int Y_FRAC    = 60;

	localparam logic signed [DIR_W-1:0] DIR_ONE = 18'sd65536;

	// Register reset values
	localparam logic [POS_W-1:0] SLAB_THICKNESS_RST   = 24'd655360;
	localparam logic [THR_W-1:0] ABSORB_THRESHOLD_RST = 17'd19661;

	// Configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_SLAB_THICKNESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABSORB_THRESHOLD = 2'd1;

	typedef enum logic [1:0] {
		OUTC_SCATTER  = 2'd0,
		OUTC_TRANSMIT = 2'd1,
		OUTC_REFLECT  = 2'd2,
		OUTC_ABSORB   = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOG,
		ST_MUL,
		ST_DECIDE
	} step_state_t;

	typedef enum logic [2:0] {
		LG_IDLE,
		LG_NORM,
		LG_ITER,
		LG_ROUND,
		LG_FIN
	} log_state_t;

	typedef struct packed {
		logic load;    // latch draws of the accepted item
		logic mul_en;  // form |cosine| * lambda
		logic commit;  // classify and update neutron state
	} trk_ctrl_t;

	// Restoring division, elaboration use only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// ln(2) in Q.60, series truncated term by term
	function automatic logic [63:0] ln2_q60();
		logic [63:0] s;
		s = '0;
		for (int n = 1; n <= 60; n++) begin
			s = s + udiv64(64'd1 << (60 - n), 64'(n));
		end
		return s;
	endfunction

	// ln(1 + 2^-k) in Q.60, alternating series
	function automatic logic [63:0] ln1p_q60(input int k);
		logic [63:0] s;
		logic [63:0] t;
		s = '0;
		for (int n = 1; n <= 60; n++) begin
			if (n * k <= 60) begin
				t = udiv64(64'd1 << (60 - n * k), 64'(n));
				if ((n % 2) == 1) begin
					s = s + t;
				end else begin
					s = s - t;
				end
			end
		end
		return s;
	endfunction

	localparam logic [63:0] LN2_Q60 = ln2_q60();

endpackage

@@ hw/rtl/slabnt_log.sv @@
module slabnt_log
	import slabnt_pkg::*;
#(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int LOG_ITERATIONS = LOG_ITERATIONS_DEF,
	localparam int LAMBDA_W      = FRAC_BITS + 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DRAW_W-1:0]   path_draw,
	output logic                done,
	output logic [LAMBDA_W-1:0] lambda
);

	localparam int X_W = 33;
	localparam int T_W = 34;
	localparam int KW  = $clog2(LOG_ITERATIONS + 1);
	localparam logic [T_W-1:0]   X_ONE      = 34'h1_0000_0000;
	localparam logic [KW-1:0]    K_LAST     = KW'(LOG_ITERATIONS);
	localparam logic [Y_W-1:0]   ROUND_BIAS = 64'd1 << (Y_FRAC - 1 - FRAC_BITS);

	// ln(1 + 2^-k) constants; entry 0 unused
	logic [Y_W-1:0] ln_tab [0:LOG_ITERATIONS];

	assign ln_tab[0] = '0;
	for (genvar g = 1; g <= LOG_ITERATIONS; g++) begin : g_tab
		localparam logic [Y_W-1:0] LN1P = ln1p_q60(g);
		assign ln_tab[g] = LN1P;
	end

	log_state_t       state_q, state_d;
	logic [X_W-1:0]   x_q, x_d;
	logic [Y_W-1:0]   y_q;
	logic [KW-1:0]    k_q, k_d;
	logic [Y_W-1:0]   addend;
	logic             y_en;
	logic [T_W-1:0]   t_sum;
	logic             t_fits;
	logic [DRAW_W:0]  draw_p1;

	assign draw_p1 = {1'b0, path_draw} + 17'd1;
	assign t_sum   = T_W'(x_q) + T_W'(x_q >> k_q);
	assign t_fits  = (t_sum <= X_ONE);

	always_comb begin
		state_d = state_q;
		x_d     = x_q;
		k_d     = k_q;
		addend  = '0;
		y_en    = 1'b0;
		done    = 1'b0;
		unique case (state_q)
			LG_IDLE: begin
				if (start) begin
					state_d = LG_NORM;
				end
			end
			LG_NORM: begin
				if (x_q[X_W-1:X_W-2] == 2'b00) begin
					x_d    = {x_q[X_W-2:0], 1'b0};
					addend = LN2_Q60;
					y_en   = 1'b1;
				end else begin
					k_d     = KW'(1);
					state_d = LG_ITER;
				end
			end
			LG_ITER: begin
				if (t_fits) begin
					x_d    = t_sum[X_W-1:0];
					addend = ln_tab[k_q];
					y_en   = 1'b1;
				end
				if (k_q == K_LAST) begin
					state_d = LG_ROUND;
				end else begin
					k_d = k_q + KW'(1);
				end
			end
			LG_ROUND: begin
				// half-up rounding through the same adder
				addend  = ROUND_BIAS;
				y_en    = 1'b1;
				state_d = LG_FIN;
			end
			LG_FIN: begin
				done    = 1'b1;
				state_d = LG_IDLE;
			end
			default: state_d = LG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q <= k_d;
		if (state_q == LG_IDLE && start) begin
			x_q <= {draw_p1, 16'b0};
			y_q <= '0;
		end else begin
			x_q <= x_d;
			if (y_en) begin
				y_q <= y_q + addend;
			end
		end
	end

	assign lambda = y_q[Y_FRAC-FRAC_BITS +: LAMBDA_W];

endmodule

@@ hw/rtl/slabnt_track.sv @@
module slabnt_track
	import slabnt_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	localparam int LAMBDA_W   = FRAC_BITS + 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  trk_ctrl_t              ctrl,
	input  logic [DRAW_W-1:0]      absorb_draw,
	input  logic [DRAW_W-1:0]      direction_draw,
	input  logic [LAMBDA_W-1:0]    lambda,
	input  logic [POS_W-1:0]       slab_thickness,
	input  logic [THR_W-1:0]       absorb_threshold,
	output outcome_t               outcome,
	output logic [COUNT_WIDTH-1:0] transmit_total,
	output logic [COUNT_WIDTH-1:0] reflect_total,
	output logic [COUNT_WIDTH-1:0] absorb_total
);

	localparam int PW     = MAG_W + LAMBDA_W;
	localparam int DISP_W = PW - 15;
	localparam int NW     = ((POS_W > DISP_W) ? POS_W : DISP_W) + 2;

	logic [DRAW_W-1:0]       adraw_q, ddraw_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [DIR_W-1:0] dir_q;
	logic [PW-1:0]           prod_q;
	logic                    dir_neg;
	logic [MAG_W-1:0]        mag;
	logic [PW:0]             prod_rnd;
	logic [DISP_W-1:0]       disp;
	logic signed [NW-1:0]    pos_x, disp_x, thick_x, next_pos;
	outcome_t                outc_d;
	logic signed [DIR_W-1:0] new_dir;

	assign dir_neg = dir_q[DIR_W-1];
	assign mag     = dir_neg ? MAG_W'(-dir_q) : MAG_W'(dir_q);

	assign prod_rnd = {1'b0, prod_q} + (PW+1)'(32768);
	assign disp     = prod_rnd[PW:16];

	assign pos_x    = $signed(NW'(pos_q));
	assign disp_x   = $signed(NW'(disp));
	assign thick_x  = $signed(NW'(slab_thickness));
	assign next_pos = dir_neg ? (pos_x - disp_x) : (pos_x + disp_x);

	assign new_dir = $signed({1'b0, ddraw_q, 1'b0}) - DIR_ONE;

	always_comb begin
		if (next_pos >= thick_x) begin
			outc_d = OUTC_TRANSMIT;
		end else if (next_pos[NW-1]) begin
			outc_d = OUTC_REFLECT;
		end else if ({1'b0, adraw_q} < absorb_threshold) begin
			outc_d = OUTC_ABSORB;
		end else begin
			outc_d = OUTC_SCATTER;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			adraw_q <= absorb_draw;
			ddraw_q <= direction_draw;
		end
		if (ctrl.mul_en) begin
			prod_q <= mag * lambda;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			dir_q          <= DIR_ONE;
			outcome        <= OUTC_SCATTER;
			transmit_total <= '0;
			reflect_total  <= '0;
			absorb_total   <= '0;
		end else if (ctrl.commit) begin
			outcome <= outc_d;
			case (outc_d)
				OUTC_SCATTER: begin
					pos_q <= next_pos[POS_W-1:0];
					dir_q <= new_dir;
				end
				OUTC_TRANSMIT: begin
					if (transmit_total != '1) transmit_total <= transmit_total + 1'b1;
				end
				OUTC_REFLECT: begin
					if (reflect_total != '1) reflect_total <= reflect_total + 1'b1;
				end
				default: begin
					if (absorb_total != '1) absorb_total <= absorb_total + 1'b1;
				end
			endcase
			if (outc_d != OUTC_SCATTER) begin
				pos_q <= '0;
				dir_q <= DIR_ONE;
			end
		end
	end

endmodule

@@ hw/rtl/slab_neutron_transport_step_top.sv @@
// One-dimensional slab neutron transport, one flight step per item. Each item
// brings three 16-bit uniform draws; the block turns the first into a free path
// -ln((d+1)/65536) with a shift-and-add logarithm, moves the current neutron by
// path times direction cosine and reports whether it scattered inside (0), was
// transmitted (1), reflected (2) or absorbed (3), along with the saturating
// totals. A finished neutron restarts at position 0 heading +1. One item is in
// flight at a time: the next item is taken only after the last one commits.
// The logarithm unit doubles d+1 until it lies in [2^15, 2^16], adding ln 2
// per doubling, then runs LOG_ITERATIONS shift-and-add iterations and a
// rounding step, all through its single 64-bit accumulator; it then hands the
// path over, the tracker multiplies it by |cosine|, classifies and commits,
// and the sequencer returns to idle, where the next item is taken. A result
// waiting on out_stall does not block the next item's logarithm, only its
// commit. Configuration writes are always taken (cfg_ready tied high) and
// must only be made while idle.
module slab_neutron_transport_step_top
	import slabnt_pkg::*;
#(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
	parameter int LOG_ITERATIONS = LOG_ITERATIONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DRAW_W-1:0]     path_draw,
	input  logic [DRAW_W-1:0]     absorb_draw,
	input  logic [DRAW_W-1:0]     direction_draw,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            outcome,
	output logic [OUT_CNT_W-1:0]  transmitted_count,
	output logic [OUT_CNT_W-1:0]  reflected_count,
	output logic [OUT_CNT_W-1:0]  absorbed_count
);

	localparam int LAMBDA_W = FRAC_BITS + 4;

	step_state_t            state_q, state_d;
	logic [POS_W-1:0]       thick_q;
	logic [THR_W-1:0]       thr_q;
	logic                   out_valid_q;
	logic                   in_accept;
	logic                   out_free;
	logic                   log_done;
	logic [LAMBDA_W-1:0]    lambda;
	trk_ctrl_t              trk_ctrl;
	outcome_t               trk_outcome;
	logic [COUNT_WIDTH-1:0] trans_cnt, refl_cnt, abs_cnt;

	// Config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_q <= SLAB_THICKNESS_RST;
			thr_q   <= ABSORB_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SLAB_THICKNESS:   thick_q <= cfg_data[POS_W-1:0];
				REG_ABSORB_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// Step sequencer
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	// result slot is free if empty or being taken this cycle
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		trk_ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					trk_ctrl.load = 1'b1;
					state_d       = ST_LOG;
				end
			end
			ST_LOG: begin
				if (log_done) state_d = ST_MUL;
			end
			ST_MUL: begin
				trk_ctrl.mul_en = 1'b1;
				state_d         = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free) begin
					trk_ctrl.commit = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (trk_ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	slabnt_log #(
		.FRAC_BITS      (FRAC_BITS),
		.LOG_ITERATIONS (LOG_ITERATIONS)
	) u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept),
		.path_draw (path_draw),
		.done      (log_done),
		.lambda    (lambda)
	);

	// Neutron state and totals; they only move on commit, so they double as
	// the result register.
	slabnt_track #(
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_track (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (trk_ctrl),
		.absorb_draw      (absorb_draw),
		.direction_draw   (direction_draw),
		.lambda           (lambda),
		.slab_thickness   (thick_q),
		.absorb_threshold (thr_q),
		.outcome          (trk_outcome),
		.transmit_total   (trans_cnt),
		.reflect_total    (refl_cnt),
		.absorb_total     (abs_cnt)
	);

	assign out_valid         = out_valid_q;
	assign outcome           = trk_outcome;
	assign transmitted_count = OUT_CNT_W'(trans_cnt);
	assign reflected_count   = OUT_CNT_W'(refl_cnt);
	assign absorbed_count    = OUT_CNT_W'(abs_cnt);

endmodule

@@ bench/tb_slab_neutron_transport_step_top.sv @@
module tb_slab_neutron_transport_step_top;
	import slabnt_pkg::*;

	// Spare register slots, writes there must leave both registers alone
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	localparam int RAND_PHASES    = 5;
	localparam int PHASE_ITEMS    = 250;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 64;

	// Expected contents of one result item
	typedef struct packed {
		outcome_t              outcome;
		logic [OUT_CNT_W-1:0]  transmitted;
		logic [OUT_CNT_W-1:0]  reflected;
		logic [OUT_CNT_W-1:0]  absorbed;
	} tally_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// Directed drill: register rows or step rows; typed rows carry the result
	// that can be read straight off the physics, the rest go to the predictor
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [DRAW_W-1:0]     path;
		logic [DRAW_W-1:0]     absorb;
		logic [DRAW_W-1:0]     dir;
		logic                  typed;
		outcome_t              w_outcome;
		logic [OUT_CNT_W-1:0]  w_trans;
		logic [OUT_CNT_W-1:0]  w_refl;
		logic [OUT_CNT_W-1:0]  w_abs;
	} drill_row_t;

	localparam int DRILL_ROWS = 29;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SLAB_THICKNESS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [DRAW_W-1:0]     path_draw = '0;
	logic [DRAW_W-1:0]     absorb_draw = '0;
	logic [DRAW_W-1:0]     direction_draw = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            outcome;
	logic [OUT_CNT_W-1:0]  transmitted_count;
	logic [OUT_CNT_W-1:0]  reflected_count;
	logic [OUT_CNT_W-1:0]  absorbed_count;

	slab_neutron_transport_step_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.path_draw         (path_draw),
		.absorb_draw       (absorb_draw),
		.direction_draw    (direction_draw),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.outcome           (outcome),
		.transmitted_count (transmitted_count),
		.reflected_count   (reflected_count),
		.absorbed_count    (absorbed_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the slab: registers, the neutron in flight and the tallies
	logic [POS_W-1:0]        slab_len   = SLAB_THICKNESS_RST;
	logic [THR_W-1:0]        absorb_cut = ABSORB_THRESHOLD_RST;
	logic [POS_W-1:0]        nt_pos     = '0;
	logic signed [DIR_W-1:0] nt_cos     = DIR_ONE;
	logic [OUT_CNT_W-1:0]    n_transmit = '0;
	logic [OUT_CNT_W-1:0]    n_reflect  = '0;
	logic [OUT_CNT_W-1:0]    n_absorb   = '0;

	// Log constants in Q.60
	logic [63:0] ln2_q;
	logic [63:0] ln_step_q [1:LOG_ITERATIONS_DEF];

	tally_t awaited_tallies [$];
	int     fail_count = 0;
	int     idle_pct = 20;    // chance in percent that either side idles
	int     stall_left = 0;
	int     quiet_cycles = 0;

	// sum of 2^(60-nk)/n, each term truncated; alternating for ln(1+2^-k)
	function automatic logic [63:0] log_series(input int k, input bit alternate);
		logic [63:0] acc;
		logic [63:0] term;
		acc = '0;
		for (int n = 1; n * k <= Y_FRAC; n++) begin
			term = (64'd1 << (Y_FRAC - n * k)) / 64'(n);
			if (alternate && (n % 2 == 0))
				acc = acc - term;
			else
				acc = acc + term;
		end
		return acc;
	endfunction

	// -ln((d+1)/65536) by normalise then shift-and-add, rounded half up
	function automatic logic [63:0] free_path(input logic [DRAW_W-1:0] d);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] t;
		x = (64'(d) + 64'd1) << 16;
		y = '0;
		while (x < 64'h8000_0000) begin
			x = x << 1;
			y = y + ln2_q;
		end
		for (int k = 1; k <= LOG_ITERATIONS_DEF; k++) begin
			t = x + (x >> k);
			if (t <= 64'h1_0000_0000) begin
				x = t;
				y = y + ln_step_q[k];
			end
		end
		return (y + (64'd1 << (Y_FRAC - 1 - FRAC_BITS_DEF))) >> (Y_FRAC - FRAC_BITS_DEF);
	endfunction

	// One flight of the tracked neutron; updates the shadow state
	function automatic tally_t fly_neutron(input logic [DRAW_W-1:0] pd,
			input logic [DRAW_W-1:0] ad, input logic [DRAW_W-1:0] dd);
		tally_t             r;
		logic signed [63:0] cos_w;
		logic signed [63:0] mag;
		logic signed [63:0] disp;
		logic signed [63:0] nxt;
		cos_w = nt_cos;
		mag = (cos_w < 0) ? -cos_w : cos_w;
		disp = (mag * $signed(free_path(pd)) + 64'sd32768) >>> 16;
		nxt = $signed(64'(nt_pos)) + ((cos_w < 0) ? -disp : disp);
		if (nxt >= $signed(64'(slab_len))) begin
			r.outcome = OUTC_TRANSMIT;
			if (n_transmit != '1)
				n_transmit = n_transmit + 1'b1;
		end else if (nxt < 0) begin
			r.outcome = OUTC_REFLECT;
			if (n_reflect != '1)
				n_reflect = n_reflect + 1'b1;
		end else if (17'(ad) < absorb_cut) begin
			r.outcome = OUTC_ABSORB;
			if (n_absorb != '1)
				n_absorb = n_absorb + 1'b1;
		end else begin
			r.outcome = OUTC_SCATTER;
			nt_pos = nxt[POS_W-1:0];
			cos_w = 2 * $signed(64'(dd)) - 64'sd65536;
			nt_cos = cos_w[DIR_W-1:0];
		end
		// fresh neutron at the near face, heading in
		if (r.outcome != OUTC_SCATTER) begin
			nt_pos = '0;
			nt_cos = DIR_ONE;
		end
		r.transmitted = n_transmit;
		r.reflected = n_reflect;
		r.absorbed = n_absorb;
		return r;
	endfunction

	// Offer one step item; possibly after a random gap, hold it until taken
	task automatic push_item(input logic [DRAW_W-1:0] pd, input logic [DRAW_W-1:0] ad,
			input logic [DRAW_W-1:0] dd, input logic typed, input tally_t want);
		tally_t got;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		path_draw <= pd;
		absorb_draw <= ad;
		direction_draw <= dd;
		do
			@(posedge clk);
		while (in_stall);
		got = fly_neutron(pd, ad, dd);
		awaited_tallies.push_back(typed ? want : got);
	endtask

	// Stop sending and wait for every result to come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_tallies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_SLAB_THICKNESS:   slab_len = val[POS_W-1:0];
			REG_ABSORB_THRESHOLD: absorb_cut = val[THR_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Directed drill. After reset: thickness 10.0, threshold 19661, neutron at 0 heading +1.
	// path 65535 gives zero path, path 0 gives the longest (about 11.09), 32767 gives ln 2.
	drill_row_t drill_plan [DRILL_ROWS] = '{
		// zero path lands on zero: stays inside, absorbed, then scattered
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 65535, 0,     0,     1, OUTC_ABSORB,   0, 0, 1},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 65535, 65535, 0,     1, OUTC_SCATTER,  0, 0, 1},
		// heading -1, long path: out the near face
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 0,     0,     0,     1, OUTC_REFLECT,  0, 1, 1},
		// heading +1, long path: through the slab
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 0,     0,     65535, 1, OUTC_TRANSMIT, 1, 1, 1},
		// draw one under and at the threshold
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 32767, 19660, 65535, 1, OUTC_ABSORB,   1, 1, 2},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 32767, 19661, 65535, 1, OUTC_SCATTER,  1, 1, 2},
		// zero thickness: everything transmits
		'{ROW_REG,  REG_SLAB_THICKNESS, 0, 0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 65535, 65535, 0,     1, OUTC_TRANSMIT, 2, 1, 2},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 0,     65535, 0,     1, OUTC_TRANSMIT, 3, 1, 2},
		// widest slab; over-wide threshold masks to 0x1ffff, absorbs all inside
		'{ROW_REG,  REG_SLAB_THICKNESS,   24'hffffff, 0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_REG,  REG_ABSORB_THRESHOLD, 24'hffffff, 0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 0,     65535, 0,     1, OUTC_ABSORB,   3, 1, 3},
		// zero threshold: nothing absorbs
		'{ROW_REG,  REG_ABSORB_THRESHOLD, 0, 0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 0,     0,     0,     1, OUTC_SCATTER,  3, 1, 3},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 65535, 0,     65535, 1, OUTC_SCATTER,  3, 1, 3},
		// spare indexes must not touch either register
		'{ROW_REG,  REG_SPARE_LO, 0,          0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_REG,  REG_SPARE_HI, 24'hffffff, 0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 0,     0,     32768, 1, OUTC_SCATTER,  3, 1, 3},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 0,     0,     0,     1, OUTC_SCATTER,  3, 1, 3},
		// thinnest slab, threshold at full scale
		'{ROW_REG,  REG_SLAB_THICKNESS,   1,     0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_REG,  REG_ABSORB_THRESHOLD, 65536, 0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 65535, 65535, 0,     1, OUTC_TRANSMIT, 4, 1, 3},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 65535, 65535, 0,     1, OUTC_ABSORB,   4, 1, 4},
		// back to the reset setting, predictor from here on
		'{ROW_REG,  REG_SLAB_THICKNESS,   655360, 0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_REG,  REG_ABSORB_THRESHOLD, 19661,  0, 0, 0, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 1,     30000, 49152, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 40000, 20000, 16384, 0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 100,   50000, 0,     0, OUTC_SCATTER, 0, 0, 0},
		'{ROW_ITEM, REG_SLAB_THICKNESS, 0, 65534, 65535, 65535, 0, OUTC_SCATTER, 0, 0, 0}
	};

	// Receiver: random stall bursts, none while idle_pct is zero
	always @(posedge clk) begin
		if (idle_pct == 0) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker: oldest expectation against each accepted result item
	tally_t head;
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (awaited_tallies.size() == 0) begin
				$error("result item with nothing expected");
				fail_count++;
			end else begin
				head = awaited_tallies.pop_front();
				if (outcome !== head.outcome) begin
					$error("outcome: expected %0d, got %0d", head.outcome, outcome);
					fail_count++;
				end
				if (transmitted_count !== head.transmitted) begin
					$error("transmitted_count: expected %0d, got %0d",
						head.transmitted, transmitted_count);
					fail_count++;
				end
				if (reflected_count !== head.reflected) begin
					$error("reflected_count: expected %0d, got %0d",
						head.reflected, reflected_count);
					fail_count++;
				end
				if (absorbed_count !== head.absorbed) begin
					$error("absorbed_count: expected %0d, got %0d",
						head.absorbed, absorbed_count);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long with no handshake on any channel means a hang
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("slab_neutron_transport_step_top regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [DRAW_W-1:0]     pd;
		logic [DRAW_W-1:0]     dd;
		logic [CFG_DATA_W-1:0] thick;
		logic [CFG_DATA_W-1:0] thr;
		ln2_q = log_series(1, 1'b0);
		for (int k = 1; k <= LOG_ITERATIONS_DEF; k++)
			ln_step_q[k] = log_series(k, 1'b1);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed drill
		foreach (drill_plan[i]) begin
			if (drill_plan[i].kind == ROW_REG) begin
				drain_results();
				write_reg(drill_plan[i].reg_idx, drill_plan[i].reg_val);
			end else begin
				push_item(drill_plan[i].path, drill_plan[i].absorb, drill_plan[i].dir,
					drill_plan[i].typed, '{drill_plan[i].w_outcome, drill_plan[i].w_trans,
					drill_plan[i].w_refl, drill_plan[i].w_abs});
			end
		end

		// random phases, a fresh setting at each; the last one runs flat out
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_results();
			case ($urandom_range(0, 5))
				0:       thick = 24'($urandom_range(1, 1000));
				1:       thick = 24'($urandom);
				2:       thick = 24'hffffff;
				default: thick = 24'($urandom_range(65536, 2000000));
			endcase
			case ($urandom_range(0, 5))
				0:       thr = 0;
				1:       thr = 65536;
				2:       thr = 24'($urandom);    // over-wide, masked by the block
				default: thr = 24'($urandom_range(0, 65536));
			endcase
			write_reg(REG_SLAB_THICKNESS, thick);
			write_reg(REG_ABSORB_THRESHOLD, thr);
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					24'($urandom));
			if (ph == RAND_PHASES - 1)
				idle_pct = 0;
			else
				idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold off mid-phase until the block has emptied
				if (ph == 1 && n == PHASE_ITEMS / 2)
					drain_results();
				case ($urandom_range(0, 15))
					0:       pd = '0;
					1:       pd = '1;
					default: pd = DRAW_W'($urandom);
				endcase
				case ($urandom_range(0, 15))
					0:       dd = '0;
					1:       dd = '1;
					2:       dd = 16'd32768;
					default: dd = DRAW_W'($urandom);
				endcase
				push_item(pd, DRAW_W'($urandom), dd, 1'b0, '0);
			end
		end

		// let the last results out, then a tail for anything stray
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_tallies.size() == 0)
			$display("slab_neutron_transport_step_top regression: pass");
		else
			$display("slab_neutron_transport_step_top regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/slabnt_pkg.sv
hw/rtl/slabnt_log.sv
hw/rtl/slabnt_track.sv
hw/rtl/slab_neutron_transport_step_top.sv
bench/tb_slab_neutron_transport_step_top.sv
